// ----- hdl/rv32im_integer_execute_top_assert.svh -----
// Assertion macros for the integer execute block
`ifndef RV32IM_INTEGER_EXECUTE_TOP_ASSERT_SVH
`define RV32IM_INTEGER_EXECUTE_TOP_ASSERT_SVH

`define RIE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("label failed");

`define RIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("label failed");

`endif

// ----- hdl/rie_pkg.sv -----
`default_nettype none
package rie_pkg;
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ILLEGAL     = 2'd1;
  localparam logic [1:0] ST_NOT_HANDLED = 2'd2;

  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;
  localparam logic [6:0] OPC_AMO      = 7'h2f;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_MADD     = 7'h43;
  localparam logic [6:0] OPC_MSUB     = 7'h47;
  localparam logic [6:0] OPC_NMSUB    = 7'h4b;
  localparam logic [6:0] OPC_NMADD    = 7'h4f;
  localparam logic [6:0] OPC_OP_FP    = 7'h53;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6f;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [31:0] SIGN32     = 32'h8000_0000;
  localparam logic [31:0] ONES32     = 32'hffff_ffff;
  localparam logic [31:0] UPPER_MASK = 32'hffff_f000;

  typedef enum logic [1:0] {
    RES_ALU,
    RES_MUL,
    RES_DIV
  } res_kind_t;
endpackage
`default_nettype wire

// ----- hdl/rv32im_integer_execute_top.sv -----
// Integer execute unit for uncompressed RV32IM instructions.
// Input channel in_valid/in_ready carries instr_pc and instr_word; output
// channel out_valid/out_ready carries next_pc, dest_reg, dest_value, status.
// cfg_we/cfg_wdata writes muldiv_enable (reset 1); write only while idle.
// One item at a time. Reset clears the register file by a sweep over all
// REG_COUNT entries during which in_ready is low.
// After transfer in, plain instructions do two register-file reads through
// one read port, then execute; multiply adds two 33x17 partial products,
// and divide and remainder add 32 steps of a one-bit shift-subtract
// divider plus sign fix. The result sits in an output register; while the
// receiver stalls the unit holds and takes nothing new. in_ready rises in
// the cycle after the result is taken.
`default_nettype none
module rv32im_integer_execute_top #(
  parameter int REG_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_instr_pc,
  input  wire logic [31:0] in_instr_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_next_pc,
  output logic [4:0]       out_dest_reg,
  output logic [31:0]      out_dest_value,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);
  import rie_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DIVF  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic        mde_r;
  logic [31:0] pc_r, word_r, a_r, b_r;
  logic [31:0] rdata;

  logic [31:0] npc_r, val_r;
  logic [4:0]  dst_r;
  logic [1:0]  st_r;

  logic [63:0] acc_r;
  logic [31:0] quo_r, rem_r, dvs_r;
  logic [5:0]  cnt_r;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [6:0] opc, f7;
  logic [4:0] rd, rs1, rs2;
  logic [2:0] f3;
  assign opc = word_r[6:0];
  assign rd  = word_r[11:7];
  assign f3  = word_r[14:12];
  assign rs1 = word_r[19:15];
  assign rs2 = word_r[24:20];
  assign f7  = word_r[31:25];

  function automatic logic rok(input logic [4:0] i);
    return {27'd0, i} < 32'(REG_COUNT);
  endfunction

  rie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [31:0] rs_val;
  logic [4:0]  rs_idx;
  assign rs_idx = (state_r == S_RD2) ? rs1 : rs2;
  assign rs_val = (rs_idx == 5'd0 || !rok(rs_idx)) ? 32'd0 : rdata;

  // rs2 arrives from the read port during EXEC and is registered at its end
  logic [31:0] b_cur;
  assign b_cur = (state_r == S_EXEC) ? rs_val : b_r;

  always_comb begin
    raddr = AW'(in_instr_word[19:15]);
    if (state_r == S_RD2) begin
      raddr = AW'(rs2);
    end
  end

  // decode and combinational execute
  logic [31:0] imm_i, imm_b, imm_j, opb, alu_v, pc4;
  logic        alt, taken, srl_alt;
  logic [1:0]  dec_st;
  res_kind_t   kind;
  logic [31:0] dec_npc, dec_val;
  logic [4:0]  dec_dst;

  assign imm_i = {{20{word_r[31]}}, word_r[31:20]};
  assign imm_b = {{19{word_r[31]}}, word_r[31], word_r[7], word_r[30:25],
                  word_r[11:8], 1'b0};
  assign imm_j = {{11{word_r[31]}}, word_r[31], word_r[19:12], word_r[20],
                  word_r[30:21], 1'b0};
  assign pc4 = pc_r + 32'd4;

  always_comb begin
    dec_st  = ST_OK;
    dec_npc = pc4;
    dec_val = 32'd0;
    dec_dst = 5'd0;
    kind    = RES_ALU;
    taken   = 1'b0;
    opb     = (opc == OPC_OP) ? b_cur : imm_i;
    alt     = (opc == OPC_OP) ? (f7 == F7_ALT) : (f3 == 3'd5 && word_r[30]);
    srl_alt = alt;
    unique case (f3)
      3'd0: alu_v = (alt && opc == OPC_OP) ? a_r - opb : a_r + opb;
      3'd1: alu_v = a_r << opb[4:0];
      3'd2: alu_v = {31'd0, $signed(a_r) < $signed(opb)};
      3'd3: alu_v = {31'd0, a_r < opb};
      3'd4: alu_v = a_r ^ opb;
      3'd5: alu_v = srl_alt ? 32'($signed(a_r) >>> opb[4:0]) : a_r >> opb[4:0];
      3'd6: alu_v = a_r | opb;
      default: alu_v = a_r & opb;
    endcase
    if (word_r[1:0] != 2'b11) begin
      dec_st = ST_NOT_HANDLED;
    end else begin
      unique case (opc)
        OPC_LOAD, OPC_LOAD_FP, OPC_MISC_MEM, OPC_STORE, OPC_STORE_FP, OPC_AMO,
        OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD, OPC_OP_FP, OPC_SYSTEM:
          dec_st = ST_NOT_HANDLED;
        OPC_OP_IMM: begin
          if (!rok(rd) || !rok(rs1)) dec_st = ST_ILLEGAL;
          else if ((f3 == 3'd1 && f7 != F7_BASE) ||
                   (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT)) dec_st = ST_ILLEGAL;
          else begin
            dec_dst = rd;
            dec_val = alu_v;
          end
        end
        OPC_OP: begin
          if (!rok(rd) || !rok(rs1) || !rok(rs2)) dec_st = ST_ILLEGAL;
          else if (f7 == F7_MULDIV) begin
            if (!mde_r) dec_st = ST_ILLEGAL;
            else begin
              dec_dst = rd;
              kind = f3[2] ? RES_DIV : RES_MUL;
            end
          end else if (f7 == F7_BASE ||
                       (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
            dec_dst = rd;
            dec_val = alu_v;
          end else dec_st = ST_ILLEGAL;
        end
        OPC_LUI: begin
          if (!rok(rd)) dec_st = ST_ILLEGAL;
          else begin
            dec_dst = rd;
            dec_val = word_r & UPPER_MASK;
          end
        end
        OPC_AUIPC: begin
          if (!rok(rd)) dec_st = ST_ILLEGAL;
          else begin
            dec_dst = rd;
            dec_val = pc_r + (word_r & UPPER_MASK);
          end
        end
        OPC_JAL: begin
          if (!rok(rd)) dec_st = ST_ILLEGAL;
          else begin
            dec_dst = rd;
            dec_val = pc4;
            dec_npc = pc_r + imm_j;
          end
        end
        OPC_JALR: begin
          if (f3 != 3'd0 || !rok(rd) || !rok(rs1)) dec_st = ST_ILLEGAL;
          else begin
            dec_dst = rd;
            dec_val = pc4;
            dec_npc = (a_r + imm_i) & ~32'd1;
          end
        end
        OPC_BRANCH: begin
          if (!rok(rs1) || !rok(rs2)) dec_st = ST_ILLEGAL;
          else begin
            unique case (f3)
              3'd0: taken = a_r == b_cur;
              3'd1: taken = a_r != b_cur;
              3'd4: taken = $signed(a_r) < $signed(b_cur);
              3'd5: taken = $signed(a_r) >= $signed(b_cur);
              3'd6: taken = a_r < b_cur;
              3'd7: taken = a_r >= b_cur;
              default: dec_st = ST_ILLEGAL;
            endcase
            if (dec_st == ST_OK && taken) dec_npc = pc_r + imm_b;
          end
        end
        default: dec_st = ST_ILLEGAL;
      endcase
    end
    if (dec_st != ST_OK) begin
      dec_npc = pc_r;
      dec_dst = 5'd0;
      kind    = RES_ALU;
    end
  end

  // multiplier: operands as 33-bit signed, two 17x33 partial products
  logic        a_sgn, b_sgn;
  logic [32:0] ma, mb;
  logic [65:0] pp;
  assign a_sgn = (f3[1:0] == 2'd1 || f3[1:0] == 2'd2) && a_r[31];
  assign b_sgn = (f3[1:0] == 2'd1) && b_r[31];
  assign ma = {a_sgn, a_r};
  assign mb = {b_sgn, b_r};
  logic [16:0] mb_part;
  logic        mb_hi;
  assign mb_hi = state_r == S_MUL2;
  assign mb_part = mb_hi ? {1'b0, mb[32:17]} : mb[16:0];
  logic signed [50:0] pprod;
  always_comb begin
    if (mb_hi) pprod = 51'($signed(ma) * $signed({mb[32], mb_part[15:0]}));
    else       pprod = 51'($signed(ma) * $signed({1'b0, mb_part}));
  end
  assign pp = mb_hi ? {pprod[48:0], 17'd0} : {{15{pprod[50]}}, pprod};

  // divider on magnitudes
  logic        dsign_a, dsign_b, dsigned;
  logic [31:0] mag_a, mag_b;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  assign dsigned = !f3[0];
  assign dsign_a = dsigned && a_r[31];
  assign dsign_b = dsigned && b_cur[31];
  assign mag_a = dsign_a ? 32'd0 - a_r : a_r;
  assign mag_b = dsign_b ? 32'd0 - b_cur : b_cur;
  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial = {rem_r[31], rem_sh} - {1'b0, dvs_r};

  logic [31:0] div_res, q_fix, r_fix;
  always_comb begin
    q_fix = (dsign_a != dsign_b) ? 32'd0 - quo_r : quo_r;
    r_fix = dsign_a ? 32'd0 - rem_r : rem_r;
    if (b_r == 32'd0) div_res = f3[1] ? a_r : ONES32;
    else if (dsigned && a_r == SIGN32 && b_r == ONES32) div_res = f3[1] ? 32'd0 : SIGN32;
    else div_res = f3[1] ? r_fix : q_fix;
  end

  logic out_fire, in_fire;
  assign in_ready = state_r == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = state_r == S_OUT;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    we    = 1'b0;
    waddr = AW'(dst_r);
    wdata = val_r;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r[AW-1:0];
        wdata = 32'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(REG_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_fire) state_nxt = S_RD2;
      S_RD2:  state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (kind)
          RES_MUL: state_nxt = S_MUL1;
          RES_DIV: state_nxt = S_DIV;
          default: state_nxt = S_OUT;
        endcase
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_OUT;
      S_DIV:  if (cnt_r == 6'd31) state_nxt = S_DIVF;
      S_DIVF: state_nxt = S_OUT;
      S_OUT: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
          we = (st_r == ST_OK) && (dst_r != 5'd0);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      mde_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) mde_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pc_r   <= in_instr_pc;
      word_r <= in_instr_word;
    end
    if (state_r == S_RD2) a_r <= rs_val;
    if (state_r == S_EXEC) begin
      b_r   <= rs_val;
    end
    unique case (state_r)
      S_EXEC: begin
        npc_r <= dec_npc;
        dst_r <= dec_dst;
        st_r  <= dec_st;
        val_r <= (dec_dst == 5'd0) ? 32'd0 : dec_val;
        acc_r <= '0;
        cnt_r <= '0;
        quo_r <= mag_a;
        rem_r <= '0;
        dvs_r <= mag_b;
      end
      S_MUL1: begin
        acc_r <= pp[63:0];
      end
      S_MUL2: begin
        acc_r <= acc_r + pp[63:0];
        if (dst_r != 5'd0) begin
          val_r <= (f3 == 3'd0) ? acc_r[31:0] + pp[31:0] : 32'((acc_r + pp[63:0]) >> 32);
        end
      end
      S_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end
      S_DIVF: if (dst_r != 5'd0) val_r <= div_res;
      default: ;
    endcase
  end

  assign out_next_pc    = npc_r;
  assign out_dest_reg   = dst_r;
  assign out_dest_value = val_r;
  assign out_status     = st_r;

`include "rv32im_integer_execute_top_assert.svh"
  `RIE_ASSERT_IMPLY(a_no_x0_write, we && state_r != S_CLEAR, waddr != '0)
  `RIE_ASSERT_IMPLY(a_not_exec_no_dst, out_valid && out_status != ST_OK,
                    out_dest_reg == 5'd0 && out_dest_value == 32'd0)
  `RIE_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(out_dest_value))
  `RIE_ASSERT_IMPLY(a_no_in_busy, in_ready, !out_valid)
endmodule
`default_nettype wire

// ----- hdl/rie_ram.sv -----
`default_nettype none
module rie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
